// ===== hdl/sbss_pkg.sv =====
// Shared types, constants and a helper function of the spectrum bar spring smoother.
`default_nettype none

package sbss_pkg;

   localparam int BAR_COUNT        = 20;
   localparam int MAX_BINS_PER_BAR = 256;

   localparam int BIN_W   = 16;
   localparam int CFG_W   = 9;
   localparam int NUM_W   = 6;
   localparam int HGT_W   = 16;
   localparam int VEL_W   = 18;
   localparam int SUM_W   = BIN_W + $clog2(MAX_BINS_PER_BAR);
   localparam int CNT_W   = $clog2(MAX_BINS_PER_BAR + 1);
   localparam int POS_W   = $clog2(BAR_COUNT + 1);
   localparam int IDX_W   = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
   localparam int STEP_W  = $clog2(SUM_W + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index taken from the word address bit of the configuration port.
   localparam logic REG_BINS_PER_BAR = 1'b0;

   // Q0.16 constants.
   localparam logic [15:0] K_SCALE    = 16'd58982;
   localparam logic [15:0] K_HMIN     = 16'd3277;
   localparam logic [15:0] K_HMAX     = 16'd31457;
   localparam logic [15:0] K_FORCE    = 16'd29491;
   localparam logic [15:0] K_DAMP     = 16'd47186;
   localparam logic [15:0] K_DEADBAND = 16'd1638;
   localparam logic [15:0] K_HALF     = 16'h8000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_TARGET,
      ST_FORCE,
      ST_VELOCITY,
      ST_DAMP,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accumulate;
      logic frame_clear;
      logic div_start;
      logic ld_scale;
      logic ld_target;
      logic ld_force;
      logic ld_velocity;
      logic ld_damp;
      logic ld_update;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic bar_open;
      logic bar_full;
      logic more_bars;
      logic div_done;
   } status_type;

   // A zero setting counts as one bin, and settings above the maximum saturate.
   function automatic logic [CNT_W-1:0] eff_bpb(input logic [CFG_W-1:0] bpb);
      logic [CNT_W-1:0] result;
      if (bpb == '0) begin
         result = CNT_W'(1);
      end else if (int'(bpb) > MAX_BINS_PER_BAR) begin
         result = CNT_W'(MAX_BINS_PER_BAR);
      end else begin
         result = CNT_W'(bpb);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sbss_divider.sv =====
// Bit-serial restoring divider that turns a bar sum into its average.
`default_nettype none

module sbss_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sbss_pkg::SUM_W-1:0]  dividend,
   input  logic [sbss_pkg::CNT_W-1:0]  divisor,
   output logic [sbss_pkg::SUM_W-1:0]  quotient,
   output logic                        done
);
   import sbss_pkg::*;

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Each step shifts in one dividend bit and tries one subtraction.
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== hdl/sbss_datapath.sv =====
// Datapath: bin accumulation, bar state, averaging and the damped spring update.
`default_nettype none

module sbss_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  sbss_pkg::cmd_type           cmd,
   output sbss_pkg::status_type        status,
   input  logic [sbss_pkg::CNT_W-1:0]  bpb_eff,
   input  logic [sbss_pkg::BIN_W-1:0]  bin_value,
   output logic [sbss_pkg::NUM_W-1:0]  bar_number,
   output logic [sbss_pkg::HGT_W-1:0]  bar_height,
   output logic                        redraw,
   output logic                        frame_changed,
   output logic                        last_bar
);
   import sbss_pkg::*;

   localparam logic signed [20:0] VW_MAX = 21'sd131071;
   localparam logic signed [20:0] VW_MIN = -21'sd131072;

   // Bar accumulation and per-bar state.
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          any_redraw_ff, any_redraw_in;
   logic [HGT_W-1:0]              heights_ff [BAR_COUNT];
   logic [HGT_W-1:0]              heights_in [BAR_COUNT];
   logic signed [VEL_W-1:0]       vel_ff [BAR_COUNT];
   logic signed [VEL_W-1:0]       vel_in [BAR_COUNT];

   // Spring pipeline registers.
   logic [SUM_W+15:0]             prod1_ff, prod1_in;
   logic [HGT_W-1:0]              target_ff, target_in;
   logic [31:0]                   prod2_ff, prod2_in;
   logic                          neg2_ff, neg2_in;
   logic signed [18:0]            v1_ff, v1_in;
   logic [34:0]                   prod3_ff, prod3_in;
   logic                          neg3_ff, neg3_in;

   // Result registers.
   logic [NUM_W-1:0]              number_ff, number_in;
   logic [HGT_W-1:0]              height_ff, height_in;
   logic                          redraw_ff, redraw_in;
   logic                          changed_ff, changed_in;
   logic                          last_ff, last_in;

   logic [SUM_W-1:0]              quotient;
   logic                          div_done;
   logic [IDX_W-1:0]              idx;
   logic [HGT_W-1:0]              h_cur;
   logic signed [VEL_W-1:0]       v_cur;
   logic                          is_last;

   logic [SUM_W+16:0]             t_sum;
   logic [SUM_W:0]                t_q;
   logic signed [16:0]            diff;
   logic [15:0]                   force_mag;
   logic [32:0]                   f_sum;
   logic signed [18:0]            f_s;
   logic [18:0]                   mag3;
   logic [35:0]                   p_sum;
   logic signed [20:0]            v_w;
   logic signed [VEL_W-1:0]       v_new;
   logic signed [18:0]            nh_w;
   logic [HGT_W-1:0]              nh;
   logic signed [16:0]            d_s;
   logic [16:0]                   d_mag;
   logic                          moved;

   sbss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (bpb_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign idx     = pos_ff[IDX_W-1:0];
   assign h_cur   = heights_ff[idx];
   assign v_cur   = vel_ff[idx];
   assign is_last = (idx == IDX_W'(BAR_COUNT - 1));

   always_comb begin
      status.bar_open  = pos_ff < POS_W'(BAR_COUNT);
      status.bar_full  = ({1'b0, count_ff} + (CNT_W+1)'(1)) >= {1'b0, bpb_eff};
      status.more_bars = ({1'b0, pos_ff} + (POS_W+1)'(1)) < (POS_W+1)'(BAR_COUNT);
      status.div_done  = div_done;
   end

   // Target: average scaled by 0.9, rounded, then clamped to the height range.
   always_comb begin
      t_sum = {1'b0, prod1_ff} + (SUM_W+17)'(K_HALF);
      t_q   = t_sum[SUM_W+16:16];
      if (t_q < (SUM_W+1)'(K_HMIN)) begin
         target_in = K_HMIN;
      end else if (t_q > (SUM_W+1)'(K_HMAX)) begin
         target_in = K_HMAX;
      end else begin
         target_in = t_q[HGT_W-1:0];
      end
   end

   // Products are taken on magnitudes so that rounding is away from zero.
   always_comb begin
      prod1_in  = (SUM_W+16)'(quotient) * (SUM_W+16)'(K_SCALE);

      diff      = $signed({1'b0, target_ff}) - $signed({1'b0, h_cur});
      force_mag = diff[16] ? 16'(-diff) : diff[15:0];
      prod2_in  = 32'(force_mag) * 32'(K_FORCE);
      neg2_in   = diff[16];

      f_sum     = {1'b0, prod2_ff} + 33'(K_HALF);
      f_s       = $signed({2'b00, f_sum[32:16]});
      v1_in     = $signed({v_cur[VEL_W-1], v_cur}) + (neg2_ff ? -f_s : f_s);

      mag3      = v1_ff[18] ? 19'(-v1_ff) : 19'(v1_ff);
      prod3_in  = 35'(mag3) * 35'(K_DAMP);
      neg3_in   = v1_ff[18];
   end

   // Final step: saturate velocity, clamp height and apply the deadband.
   always_comb begin
      p_sum = {1'b0, prod3_ff} + 36'(K_HALF);
      v_w   = neg3_ff ? -$signed({1'b0, p_sum[35:16]}) : $signed({1'b0, p_sum[35:16]});
      if (v_w > VW_MAX) begin
         v_new = VW_MAX[VEL_W-1:0];
      end else if (v_w < VW_MIN) begin
         v_new = VW_MIN[VEL_W-1:0];
      end else begin
         v_new = v_w[VEL_W-1:0];
      end
      nh_w = $signed({3'b000, h_cur}) + $signed({v_new[VEL_W-1], v_new});
      if (nh_w < $signed({3'b000, K_HMIN})) begin
         nh = K_HMIN;
      end else if (nh_w > $signed({3'b000, K_HMAX})) begin
         nh = K_HMAX;
      end else begin
         nh = nh_w[HGT_W-1:0];
      end
      d_s   = $signed({1'b0, nh}) - $signed({1'b0, h_cur});
      d_mag = d_s[16] ? 17'(-d_s) : 17'(d_s);
      moved = d_mag > 17'(K_DEADBAND);
   end

   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      any_redraw_in = any_redraw_ff;
      heights_in    = heights_ff;
      vel_in        = vel_ff;
      number_in     = number_ff;
      height_in     = height_ff;
      redraw_in     = redraw_ff;
      changed_in    = changed_ff;
      last_in       = last_ff;

      if (cmd.accumulate && status.bar_open) begin
         sum_in   = sum_ff + SUM_W'(bin_value);
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.ld_update) begin
         vel_in[idx] = v_new;
         if (moved) begin
            heights_in[idx] = nh;
            any_redraw_in   = 1'b1;
         end
         number_in  = NUM_W'(idx);
         height_in  = moved ? nh : h_cur;
         redraw_in  = moved;
         last_in    = is_last;
         changed_in = is_last && (any_redraw_ff || moved);
      end

      if (cmd.advance) begin
         sum_in   = '0;
         count_in = '0;
         pos_in   = pos_ff + POS_W'(1);
         if (is_last) begin
            any_redraw_in = 1'b0;
         end
      end

      // A frame end overrides everything and starts the next frame.
      if (cmd.frame_clear) begin
         sum_in        = '0;
         count_in      = '0;
         pos_in        = '0;
         any_redraw_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         any_redraw_ff <= 1'b0;
         for (int i = 0; i < BAR_COUNT; i++) begin
            heights_ff[i] <= K_HMIN;
            vel_ff[i]     <= '0;
         end
      end else begin
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         any_redraw_ff <= any_redraw_in;
         heights_ff    <= heights_in;
         vel_ff        <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_scale) begin
         prod1_ff <= prod1_in;
      end
      if (cmd.ld_target) begin
         target_ff <= target_in;
      end
      if (cmd.ld_force) begin
         prod2_ff <= prod2_in;
         neg2_ff  <= neg2_in;
      end
      if (cmd.ld_velocity) begin
         v1_ff <= v1_in;
      end
      if (cmd.ld_damp) begin
         prod3_ff <= prod3_in;
         neg3_ff  <= neg3_in;
      end
      number_ff  <= number_in;
      height_ff  <= height_in;
      redraw_ff  <= redraw_in;
      changed_ff <= changed_in;
      last_ff    <= last_in;
   end

   assign bar_number    = number_ff;
   assign bar_height    = height_ff;
   assign redraw        = redraw_ff;
   assign frame_changed = changed_ff;
   assign last_bar      = last_ff;

endmodule

`default_nettype wire

// ===== hdl/sbss_ctrl.sv =====
// Controller state machine that sequences accumulation, division and the spring update.
`default_nettype none

module sbss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_frame_end,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sbss_pkg::status_type  status,
   output sbss_pkg::cmd_type     cmd
);
   import sbss_pkg::*;

   state_type state_ff, state_in;
   logic      fend_ff, fend_in;
   logic      take;

   assign take = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.bar_open && (status.bar_full || req_frame_end)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_TARGET;
            end
         end
         ST_TARGET: begin
            state_in = ST_FORCE;
         end
         ST_FORCE: begin
            state_in = ST_VELOCITY;
         end
         ST_VELOCITY: begin
            state_in = ST_DAMP;
         end
         ST_DAMP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               // At a frame end the remaining bars finish one after another.
               if (fend_ff && status.more_bars) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.accumulate  = req_valid;
            cmd.frame_clear = req_valid && req_frame_end && !status.bar_open;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.ld_scale = status.div_done;
         end
         ST_TARGET: begin
            cmd.ld_target = 1'b1;
         end
         ST_FORCE: begin
            cmd.ld_force = 1'b1;
         end
         ST_VELOCITY: begin
            cmd.ld_velocity = 1'b1;
         end
         ST_DAMP: begin
            cmd.ld_damp = 1'b1;
         end
         ST_UPDATE: begin
            cmd.ld_update = 1'b1;
         end
         ST_RESULT: begin
            rsp_valid       = 1'b1;
            cmd.advance     = rsp_ready;
            cmd.frame_clear = rsp_ready && fend_ff && !status.more_bars;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign fend_in = take ? req_frame_end : fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fend_ff  <= fend_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/spectrum_bar_spring_smoother.sv =====
// Top level of the spectrum bar spring smoother: register port, controller and datapath.
//
//   channel  direction  transaction
//   req      in         one spectrum bin with its frame end mark
//   rsp      out        one updated bar: number, height, redraw and frame flags
//   csr      in/out     APB-style access to bins_per_bar at byte address 0
//
// A bin that finishes no bar leaves the block idle for the next bin. A bin that finishes a bar
// closes the input while the block loads the bit-serial divider, waits while it produces one
// quotient bit per cycle and flags completion, runs five spring stages and offers the result.
// At a frame end each remaining bar runs the same sequence before the next bin is taken.
// A stalled rsp holds the block; reset needs no clearing pass.
`default_nettype none

module spectrum_bar_spring_smoother (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sbss_pkg::BIN_W-1:0]       req_bin_value,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sbss_pkg::NUM_W-1:0]       rsp_bar_number,
   output logic [sbss_pkg::HGT_W-1:0]       rsp_bar_height,
   output logic                             rsp_redraw,
   output logic                             rsp_frame_changed,
   output logic                             rsp_last_bar,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sbss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sbss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sbss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sbss_pkg::*;

   logic [CFG_W-1:0] bpb_ff, bpb_in;
   logic             reg_hit;
   cmd_type          cmd;
   status_type       status;

   assign reg_hit    = csr_paddr[CSR_ADDR_W-1] == REG_BINS_PER_BAR;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(bpb_ff) : '0;

   always_comb begin
      bpb_in = bpb_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         bpb_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpb_ff <= CFG_W'(1);
      end else begin
         bpb_ff <= bpb_in;
      end
   end

   sbss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   sbss_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .bpb_eff       (eff_bpb(bpb_ff)),
      .bin_value     (req_bin_value),
      .bar_number    (rsp_bar_number),
      .bar_height    (rsp_bar_height),
      .redraw        (rsp_redraw),
      .frame_changed (rsp_frame_changed),
      .last_bar      (rsp_last_bar)
   );

   // The block never takes a bin while a result is on offer.
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("bin taken while a bar result is pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_height >= K_HMIN) && (rsp_bar_height <= K_HMAX))
      else $error("bar height outside the clamp range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_changed |-> rsp_last_bar)
      else $error("frame change flag on a bar other than the last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bar |-> rsp_bar_number == NUM_W'(BAR_COUNT - 1))
      else $error("last bar flag on the wrong bar number");

   // After the last bar is taken, the next bar result needs a new frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_bar |=> !rsp_valid)
      else $error("result offered straight after the last bar");

endmodule

`default_nettype wire
